[rtl/lpc_pkg.sv]
package lpc_pkg;

	// Default build sizes
	localparam int LPC_MAX_WIDTH  = 1024;
	localparam int LPC_PIXEL_BITS = 16;

	// Register field widths
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_DATA_W = 13;
	// one bit above the height field: the flush runs the input row up to height+1
	localparam int ROW_W      = 14;

	// Register reset values
	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 13'd1;

	// Register indexes on the config port
	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} lpc_cfg_idx_t;

	// Input item kinds carried on s_tuser
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Per-item control carried from the address stage to the window stage
	typedef struct packed {
		logic produce;   // item releases a result
		logic last;      // that result closes the frame
		logic has_up;
		logic has_down;
		logic has_left;
		logic has_right;
		logic fwd;       // line entry comes from the write in flight, not the RAM
	} lpc_ctl_t;

endpackage

[rtl/local_peak_clip_filter.sv]
// Four-neighbor peak clipping filter on a raster frame.
// s_* carries input items: tuser is the item kind (pixel or drain), tdata the pixel.
// m_* carries results: tdata the filtered pixel, tuser set when the pixel was
// clipped down to its neighbor maximum, tlast on the final pixel of the frame.
// cfg_* writes frame_width (index 0) or frame_height (index 1); a write also
// restarts the frame. Write only while the block is idle.
// One item is taken per cycle while s_tready is high. A result belongs to the
// pixel that entered frame_width+1 items earlier; after the last pixel send
// frame_width+1 drain items to flush the frame. Drain items sent while pixels
// are expected are dropped. For the item that releases a result, the line RAM
// is read at its accept into the window stage, and the window compare is
// registered into the output register, raising m_tvalid, when that stage advances.
// Both line rows live in one RAM entry per column, read and written back once per
// item; back-to-back hits on the same column (one-pixel-wide frames, or the first
// pixel after a frame ends) forward.
// With a result waiting and m_tready low, the output register holds, the
// pipeline behind it stops, s_tready drops; an item without a result still passes.
// Reset: frame 1024 x 1, counters at the frame start. The line RAM is not
// cleared; stale values that a frame reads before writing them reach no result.
module local_peak_clip_filter import lpc_pkg::*; #(
	parameter int MAX_WIDTH  = LPC_MAX_WIDTH,
	parameter int PIXEL_BITS = LPC_PIXEL_BITS,
	localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_W-1:0]     s_tdata,    // [PIXEL_BITS-1:0] pixel_in
	input  logic                  s_tuser,    // [0] action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_W-1:0]     m_tdata,    // [PIXEL_BITS-1:0] pixel_out
	output logic                  m_tuser,    // [0] was_clipped
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  lpc_cfg_idx_t          cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int P  = PIXEL_BITS;

	// config registers
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [31:0]      w_eff;
	logic [AW-1:0]    wm1;
	logic [ROW_W-1:0] hm1;

	// position counters
	logic [AW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [AW-1:0]    out_col_q;
	logic [ROW_W-1:0] out_row_q;

	// address stage
	logic          pixel_phase;
	logic          s_acc;
	logic          take;
	logic          produce0;
	logic          last0;
	logic [P-1:0]  v0;
	lpc_ctl_t      ctl0;

	// window stage
	logic          s1_valid_q;
	lpc_ctl_t      ctl_s1;
	logic [AW-1:0] col_s1;
	logic [P-1:0]  v_s1;
	logic [2*P-1:0] fwd_data_s1;
	logic          s1_adv;

	logic [2*P-1:0] ram_rdata;
	logic [2*P-1:0] rd_eff;
	logic [2*P-1:0] wr_data;
	logic [P-1:0]   up_rd;
	logic [P-1:0]   mid_rd;

	logic [P-1:0] cw1_q;
	logic [P-1:0] cw2_q;
	logic [P-1:0] up_tap_q;
	logic [P-1:0] down_tap_q;

	logic [P-1:0] n_up, n_down, n_left, n_right;
	logic [P-1:0] mx_v, mx_h, mx;
	logic         any_nb;
	logic         clip;
	logic [P-1:0] res;

	// output register
	logic         m_valid_q;
	logic [P-1:0] pix_q;
	logic         clip_q;
	logic         last_q;

	// effective frame size
	always_comb begin
		if (fw_q == '0) begin
			w_eff = 32'd1;
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = 32'(fw_q);
		end
		wm1 = AW'(w_eff - 32'd1);
		hm1 = (fh_q == '0) ? '0 : ROW_W'(fh_q - FH_W'(1));
	end

	assign cfg_ready = 1'b1;

	// address stage: item classification and neighbor flags
	always_comb begin
		pixel_phase = (in_row_q <= hm1);
		s_acc       = s_tvalid && s_tready;
		take        = s_acc && !(pixel_phase && (s_tuser == ACT_DRAIN));
		produce0    = (in_row_q > ROW_W'(1)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
		last0       = produce0 && (out_row_q == hm1) && (out_col_q == wm1);
		v0          = pixel_phase ? s_tdata[P-1:0] : '0;

		ctl0.produce   = produce0;
		ctl0.last      = last0;
		ctl0.has_up    = (out_row_q != '0);
		ctl0.has_down  = (out_row_q != hm1);
		ctl0.has_left  = (out_col_q != '0);
		ctl0.has_right = (out_col_q != wm1);
		ctl0.fwd       = s1_adv && (col_s1 == in_col_q);
	end

	// config and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= FW_RESET;
			fh_q      <= FH_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: fh_q <= cfg_data[FH_W-1:0];
				default:          fw_q <= fw_q;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (last0) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_q == wm1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
				if (produce0) begin
					if (out_col_q == wm1) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + AW'(1);
					end
				end
			end
		end
	end

	// window stage advances unless its result cannot enter the output register
	assign s1_adv   = s1_valid_q && (!ctl_s1.produce || !m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			ctl_s1     <= '0;
		end else if (s_tready) begin
			s1_valid_q <= take;
			if (take) begin
				ctl_s1 <= ctl0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && take) begin
			col_s1      <= in_col_q;
			v_s1        <= v0;
			fwd_data_s1 <= wr_data;
		end
	end

	// line RAM: one entry per column holds {upper row, middle row}
	lpc_ram #(
		.WIDTH (2 * P),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (take),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	// read-modify-write: middle moves up, new pixel becomes middle
	always_comb begin
		rd_eff  = ctl_s1.fwd ? fwd_data_s1 : ram_rdata;
		up_rd   = rd_eff[2*P-1:P];
		mid_rd  = rd_eff[P-1:0];
		wr_data = {mid_rd, v_s1};
	end

	// neighbor max and clip decision; missing neighbors count as zero
	always_comb begin
		n_up    = ctl_s1.has_up    ? up_tap_q   : '0;
		n_down  = ctl_s1.has_down  ? down_tap_q : '0;
		n_left  = ctl_s1.has_left  ? cw1_q      : '0;
		n_right = ctl_s1.has_right ? mid_rd     : '0;
		mx_v    = (n_up > n_down) ? n_up : n_down;
		mx_h    = (n_left > n_right) ? n_left : n_right;
		mx      = (mx_v > mx_h) ? mx_v : mx_h;
		any_nb  = ctl_s1.has_up || ctl_s1.has_down || ctl_s1.has_left || ctl_s1.has_right;
		clip    = any_nb && (cw2_q > mx);
		res     = clip ? mx : cw2_q;
	end

	// center row taps and vertical taps
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cw1_q      <= cw2_q;
			cw2_q      <= mid_rd;
			up_tap_q   <= up_rd;
			down_tap_q <= v_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv && ctl_s1.produce) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.produce) begin
			pix_q  <= res;
			clip_q <= clip;
			last_q <= ctl_s1.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DATA_W'(pix_q);
	assign m_tuser  = clip_q;
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	// same-column forwarding only arises in a one-pixel-wide frame or on the
	// first pixel after a frame ends
	a_fwd_single_col: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && ctl_s1.fwd |-> (wm1 == '0) || (col_s1 == '0))
		else $error("line forwarding away from column zero in a wide frame");

	// the final result of a frame returns all counters to the frame start
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && last0 |=> (in_col_q == '0) && (in_row_q == '0)
			&& (out_col_q == '0) && (out_row_q == '0))
		else $error("counters not cleared after end of frame");

	// the output row never runs ahead of the input row
	a_out_behind_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= in_row_q)
		else $error("output row ahead of input row");
`endif

endmodule

[rtl/lpc_ram.sv]
module lpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
